>>> design/ashp_pkg.sv
package ashp_pkg;

    localparam int FINE_BIN_COUNT   = 32;
    localparam int COARSE_BIN_COUNT = 6;
    localparam int NBINS            = FINE_BIN_COUNT + COARSE_BIN_COUNT;
    localparam int FINE_LIMIT       = 8 * FINE_BIN_COUNT;

    localparam int SIZE_W   = 24;
    localparam int CNT_W    = 32;
    localparam int BINNUM_W = 6;
    localparam int ADDR_W   = $clog2(NBINS);
    localparam int EPOCH_W  = 8;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    localparam logic REC_HEADER = 1'b0;
    localparam logic REC_BIN    = 1'b1;

    // One bin entry in the histogram memory.
    // tag is the peak epoch at the last write; an entry written before the
    // latest peak reads its live count as its snapshot.
    typedef struct packed {
        logic [CNT_W-1:0]   req;
        logic [CNT_W-1:0]   live;
        logic [CNT_W-1:0]   snap;
        logic [EPOCH_W-1:0] tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_OLD,
        S_NEW,
        S_SWEEP_RD,
        S_SWEEP_WR,
        S_HDR,
        S_DUMP_RD,
        S_DUMP_WR
    } t_state;

    function automatic logic [ADDR_W-1:0] size_to_bin(input logic [SIZE_W-1:0] n);
        logic [ADDR_W-1:0] b;
        logic [SIZE_W-1:0] nm1;
        nm1 = n - SIZE_W'(1);
        b   = '0;
        if (n == '0) begin
            b = '0;
        end else if (32'(n) <= 32'(FINE_LIMIT)) begin
            b = ADDR_W'(nm1 >> 3);
        end else begin
            b = ADDR_W'(FINE_BIN_COUNT);
            // thresholds rise monotonically, so counting exceeded ones gives the bin
            for (int k = 0; k < COARSE_BIN_COUNT - 1; k++) begin
                if (64'(n) > (64'(2 * FINE_LIMIT) << k)) begin
                    b = b + ADDR_W'(1);
                end
            end
        end
        return b;
    endfunction

    function automatic logic [CNT_W-1:0] eff_snap(input t_entry e,
                                                  input logic [EPOCH_W-1:0] epoch);
        return (e.tag != epoch) ? e.live : e.snap;
    endfunction

endpackage

>>> design/alloc_size_histogram_peak.sv
// Allocation size histogram with peak snapshot.
// An event passes through three states (accept, old-bin update, new-bin update) in
// the single-port-write histogram memory; a new event is taken only once the last is through.
// Every 256th peak adds a snapshot sweep (a read and a write per bin); a dump adds a header
// record and a read and a write per bin, plus any output stall. Records leave through an output register.
// Reset: synchronous, active low; a clearing pass of the memory follows.
module alloc_size_histogram_peak (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [47:0]  i_s_axis_tdata,  // old_size[23:0], new_size[47:24]
    input  logic         i_s_axis_tuser,  // had_old_block
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [135:0] o_m_axis_tdata,  // bin_number[5:0], bin_requests[37:6],
                                          // bin_live_at_peak[69:38],
                                          // peak_objects[101:70],
                                          // peak_bytes_out[133:102], zero pad
    output logic         o_m_axis_tuser,  // record_kind
    output logic         o_m_axis_tlast   // last_of_dump
);

    localparam int AW = ashp_pkg::ADDR_W;
    localparam int CW = ashp_pkg::CNT_W;
    localparam int SW = ashp_pkg::SIZE_W;
    localparam int EW = ashp_pkg::EPOCH_W;
    localparam int NB = ashp_pkg::NBINS;
    localparam int BW = ashp_pkg::BINNUM_W;

    ashp_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_idx, n_idx;
    logic          r_had_old, n_had_old;
    logic [SW-1:0] r_old_size, n_old_size;
    logic [SW-1:0] r_new_size, n_new_size;
    logic [AW-1:0] r_old_bin, n_old_bin;
    logic [AW-1:0] r_new_bin, n_new_bin;
    logic          r_fwd, n_fwd;
    ashp_pkg::t_entry r_fwd_entry, n_fwd_entry;
    logic [CW-1:0] r_live_obj, n_live_obj;
    logic [CW-1:0] r_live_bytes, n_live_bytes;
    logic [CW-1:0] r_peak_obj, n_peak_obj;
    logic [CW-1:0] r_peak_bytes, n_peak_bytes;
    logic [EW-1:0] r_epoch, n_epoch;
    logic [NB-1:0] r_nz, n_nz;

    logic          r_out_valid, n_out_valid;
    logic          r_out_kind, n_out_kind;
    logic          r_out_last, n_out_last;
    logic [BW-1:0] r_out_bin, n_out_bin;
    logic [CW-1:0] r_out_req, n_out_req;
    logic [CW-1:0] r_out_atpk, n_out_atpk;
    logic [CW-1:0] r_out_pobj, n_out_pobj;
    logic [CW-1:0] r_out_pbytes, n_out_pbytes;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    ashp_pkg::t_entry ram_wdata, ram_rdata;

    logic [SW-1:0] in_old_size, in_new_size;
    logic [AW-1:0] in_old_bin, in_new_bin;
    logic          out_free;
    logic          idx_last;
    ashp_pkg::t_entry e_cur, e_mod;
    logic [CW-1:0] bytes_sum;
    logic [NB-1:0] nz_above;

    assign in_old_size = i_s_axis_tdata[SW-1:0];
    assign in_new_size = i_s_axis_tdata[2*SW-1:SW];
    assign in_old_bin  = ashp_pkg::size_to_bin(in_old_size);
    assign in_new_bin  = ashp_pkg::size_to_bin(in_new_size);
    assign out_free    = !r_out_valid || i_m_axis_tready;
    assign idx_last    = (r_idx == AW'(NB - 1));
    assign nz_above    = r_nz >> r_idx;

    ashp_ram #(
        .WIDTH(ashp_pkg::ENTRY_W),
        .DEPTH(NB)
    ) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_had_old    = r_had_old;
        n_old_size   = r_old_size;
        n_new_size   = r_new_size;
        n_old_bin    = r_old_bin;
        n_new_bin    = r_new_bin;
        n_fwd        = r_fwd;
        n_fwd_entry  = r_fwd_entry;
        n_live_obj   = r_live_obj;
        n_live_bytes = r_live_bytes;
        n_peak_obj   = r_peak_obj;
        n_peak_bytes = r_peak_bytes;
        n_epoch      = r_epoch;
        n_nz         = r_nz;

        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_last   = r_out_last;
        n_out_bin    = r_out_bin;
        n_out_req    = r_out_req;
        n_out_atpk   = r_out_atpk;
        n_out_pobj   = r_out_pobj;
        n_out_pbytes = r_out_pbytes;

        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_idx;

        o_s_axis_tready = 1'b0;
        e_cur     = ram_rdata;
        e_mod     = ram_rdata;
        bytes_sum = r_live_bytes + CW'(r_new_size);

        unique case (r_state)
            ashp_pkg::S_CLEAR: begin
                ram_we = 1'b1;
                if (idx_last) begin
                    n_idx   = '0;
                    n_state = ashp_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end

            ashp_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_had_old  = i_s_axis_tuser;
                    n_old_size = in_old_size;
                    n_new_size = in_new_size;
                    n_old_bin  = in_old_bin;
                    n_new_bin  = in_new_bin;
                    ram_re     = 1'b1;
                    ram_raddr  = in_old_bin;
                    n_state    = ashp_pkg::S_OLD;
                end
            end

            ashp_pkg::S_OLD: begin
                e_mod.live = ram_rdata.live - CW'(1);
                e_mod.snap = ashp_pkg::eff_snap(ram_rdata, r_epoch);
                e_mod.tag  = r_epoch;
                if (r_had_old) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_old_bin;
                    ram_wdata    = e_mod;
                    n_live_obj   = r_live_obj - CW'(1);
                    n_live_bytes = r_live_bytes - CW'(r_old_size);
                end
                // read of the new bin races the write above; forward if same bin
                ram_re      = 1'b1;
                ram_raddr   = r_new_bin;
                n_fwd       = r_had_old && (r_new_bin == r_old_bin);
                n_fwd_entry = e_mod;
                n_state     = ashp_pkg::S_NEW;
            end

            ashp_pkg::S_NEW: begin
                e_cur      = r_fwd ? r_fwd_entry : ram_rdata;
                e_mod      = e_cur;
                e_mod.req  = e_cur.req + CW'(1);
                e_mod.live = e_cur.live + CW'(1);
                e_mod.snap = ashp_pkg::eff_snap(e_cur, r_epoch);
                e_mod.tag  = r_epoch;
                n_state    = ashp_pkg::S_IDLE;
                if (r_new_size != '0) begin
                    ram_we          = 1'b1;
                    ram_waddr       = r_new_bin;
                    ram_wdata       = e_mod;
                    n_nz[r_new_bin] = (e_mod.req != '0);
                    n_live_obj      = r_live_obj + CW'(1);
                    n_live_bytes    = bytes_sum;
                    if (bytes_sum > r_peak_bytes) begin
                        n_peak_bytes = bytes_sum;
                        n_peak_obj   = r_live_obj + CW'(1);
                        // a new epoch makes every entry's snapshot its live count
                        if (r_epoch == ashp_pkg::EPOCH_MAX) begin
                            n_epoch = '0;
                            n_idx   = '0;
                            n_state = ashp_pkg::S_SWEEP_RD;
                        end else begin
                            n_epoch = r_epoch + EW'(1);
                        end
                    end
                end else if (r_had_old && (r_live_obj == '0)) begin
                    n_state = ashp_pkg::S_HDR;
                end
            end

            ashp_pkg::S_SWEEP_RD: begin
                ram_re  = 1'b1;
                n_state = ashp_pkg::S_SWEEP_WR;
            end

            ashp_pkg::S_SWEEP_WR: begin
                e_mod.snap = ram_rdata.live;
                e_mod.tag  = '0;
                ram_we     = 1'b1;
                ram_wdata  = e_mod;
                if (idx_last) begin
                    n_idx   = '0;
                    n_state = ashp_pkg::S_IDLE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = ashp_pkg::S_SWEEP_RD;
                end
            end

            ashp_pkg::S_HDR: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = ashp_pkg::REC_HEADER;
                    n_out_last   = (r_nz == '0);
                    n_out_bin    = '0;
                    n_out_req    = '0;
                    n_out_atpk   = '0;
                    n_out_pobj   = r_peak_obj;
                    n_out_pbytes = r_peak_bytes;
                    n_peak_obj   = '0;
                    n_peak_bytes = '0;
                    n_idx        = '0;
                    n_state      = ashp_pkg::S_DUMP_RD;
                end
            end

            ashp_pkg::S_DUMP_RD: begin
                ram_re  = 1'b1;
                n_state = ashp_pkg::S_DUMP_WR;
            end

            ashp_pkg::S_DUMP_WR: begin
                // read data holds while no new read is issued
                if (!r_nz[r_idx] || out_free) begin
                    if (r_nz[r_idx]) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = ashp_pkg::REC_BIN;
                        n_out_last   = (nz_above[NB-1:1] == '0);
                        n_out_bin    = BW'(r_idx);
                        n_out_req    = ram_rdata.req;
                        n_out_atpk   = ashp_pkg::eff_snap(ram_rdata, r_epoch);
                        n_out_pobj   = '0;
                        n_out_pbytes = '0;
                    end
                    e_mod.req  = '0;
                    e_mod.snap = '0;
                    e_mod.tag  = r_epoch;
                    ram_we     = 1'b1;
                    ram_wdata  = e_mod;
                    if (idx_last) begin
                        n_idx   = '0;
                        n_nz    = '0;
                        n_state = ashp_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = ashp_pkg::S_DUMP_RD;
                    end
                end
            end

            default: begin
                n_state = ashp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ashp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_live_obj   <= '0;
            r_live_bytes <= '0;
            r_peak_obj   <= '0;
            r_peak_bytes <= '0;
            r_epoch      <= '0;
            r_nz         <= '0;
            r_out_valid  <= 1'b0;
            r_fwd        <= 1'b0;
        end else begin
            r_idx        <= n_idx;
            r_live_obj   <= n_live_obj;
            r_live_bytes <= n_live_bytes;
            r_peak_obj   <= n_peak_obj;
            r_peak_bytes <= n_peak_bytes;
            r_epoch      <= n_epoch;
            r_nz         <= n_nz;
            r_out_valid  <= n_out_valid;
            r_fwd        <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_had_old    <= n_had_old;
        r_old_size   <= n_old_size;
        r_new_size   <= n_new_size;
        r_old_bin    <= n_old_bin;
        r_new_bin    <= n_new_bin;
        r_fwd_entry  <= n_fwd_entry;
        r_out_kind   <= n_out_kind;
        r_out_last   <= n_out_last;
        r_out_bin    <= n_out_bin;
        r_out_req    <= n_out_req;
        r_out_atpk   <= n_out_atpk;
        r_out_pobj   <= n_out_pobj;
        r_out_pbytes <= n_out_pbytes;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {2'b00, r_out_pbytes, r_out_pobj, r_out_atpk, r_out_req,
                              r_out_bin};

`ifndef ASSERT_OFF
    a_dump_at_zero_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ashp_pkg::S_HDR) |-> (r_live_obj == '0))
        else $error("dump started with live objects outstanding");

    a_bin_record_no_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == ashp_pkg::REC_BIN))
            |-> ((r_out_pobj == '0) && (r_out_pbytes == '0)))
        else $error("per-bin record carries peak totals");

    a_sweep_epoch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ashp_pkg::S_SWEEP_RD) || (r_state == ashp_pkg::S_SWEEP_WR))
            |-> (r_epoch == '0))
        else $error("snapshot sweep with nonzero epoch");

    a_header_after_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ashp_pkg::S_HDR) && $changed(r_state)
            |-> ($past(r_state) == ashp_pkg::S_NEW) && (r_new_size == '0))
        else $error("dump entered from unexpected state");
`endif

endmodule

>>> design/ashp_ram.sv
module ashp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/tb_alloc_size_histogram_peak.sv
module tb_alloc_size_histogram_peak;

    localparam int CNT_W          = ashp_pkg::CNT_W;
    localparam int SIZE_W         = ashp_pkg::SIZE_W;
    localparam int NBINS          = ashp_pkg::NBINS;
    localparam int FINE_LIMIT     = ashp_pkg::FINE_LIMIT;
    localparam int FINE_BIN_COUNT = ashp_pkg::FINE_BIN_COUNT;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic             kind;
        logic [5:0]       bin;
        logic [CNT_W-1:0] reqs;
        logic [CNT_W-1:0] at_peak;
        logic [CNT_W-1:0] pk_objs;
        logic [CNT_W-1:0] pk_bytes;
        logic             last;
    } t_dump_rec;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [47:0]  s_tdata = '0;   // old_size[23:0], new_size[47:24]
    logic         s_tuser = 1'b0; // had_old_block
    logic         m_tready = 1'b0;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [135:0] o_m_axis_tdata; // bin_number, bin_requests, bin_live_at_peak,
                                  // peak_objects, peak_bytes_out, zero pad
    logic         o_m_axis_tuser; // record_kind
    logic         o_m_axis_tlast; // last_of_dump

    alloc_size_histogram_peak dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // histogram shadow state
    logic [CNT_W-1:0] req_per_bin  [NBINS];
    logic [CNT_W-1:0] live_per_bin [NBINS];
    logic [CNT_W-1:0] snap_per_bin [NBINS];
    logic [CNT_W-1:0] live_objs = '0;
    logic [CNT_W-1:0] peak_objs = '0;
    logic [CNT_W-1:0] live_bytes = '0;
    logic [CNT_W-1:0] peak_bytes = '0;

    t_dump_rec pending_records [$];
    logic [SIZE_W-1:0] open_blocks [$];
    logic [SIZE_W-1:0] boundary_sizes [12] = '{24'd1, 24'd8, 24'd9, 24'd256, 24'd257,
        24'd512, 24'd513, 24'd4096, 24'd4097, 24'd8192, 24'd8193, 24'hFFFFFF};

    int mismatch_count = 0;
    int items_sent = 0;
    int burst_left = 0;
    int gap_pending = 1;
    int quiet_cycles = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    logic [31:0] stall_pattern = '1;
    int pat_pos = 0;

    function automatic int unsigned bin_of(input logic [SIZE_W-1:0] sz);
        int unsigned b;
        longint unsigned top;
        if (sz == '0) return 0;
        if (32'(sz) <= FINE_LIMIT) return (32'(sz) - 1) / 8;
        b = FINE_BIN_COUNT;
        top = 2 * FINE_LIMIT;
        while (64'(sz) > top && b < NBINS - 1) begin
            top = top << 1;
            b++;
        end
        return b;
    endfunction

    function automatic t_dump_rec make_rec(input logic kind, input int unsigned bin,
                                           input logic [CNT_W-1:0] reqs, at_peak,
                                           input logic [CNT_W-1:0] pk_objs, pk_bytes);
        t_dump_rec r;
        r.kind = kind;
        r.bin = 6'(bin);
        r.reqs = reqs;
        r.at_peak = at_peak;
        r.pk_objs = pk_objs;
        r.pk_bytes = pk_bytes;
        r.last = 1'b0;
        return r;
    endfunction

    // Update the shadow histogram for one accepted event; queue any dump it causes.
    task automatic tally_event(input logic had_old, input logic [SIZE_W-1:0] old_sz,
                               input logic [SIZE_W-1:0] new_sz);
        int unsigned b;
        t_dump_rec batch [$];
        if (had_old) begin
            b = bin_of(old_sz);
            live_per_bin[b] -= 1;
            live_objs -= 1;
            live_bytes -= 32'(old_sz);
        end
        if (new_sz != '0) begin
            b = bin_of(new_sz);
            req_per_bin[b] += 1;
            live_per_bin[b] += 1;
            live_objs += 1;
            live_bytes += 32'(new_sz);
            if (live_bytes > peak_bytes) begin
                peak_bytes = live_bytes;
                peak_objs = live_objs;
                snap_per_bin = live_per_bin;
            end
        end
        if (had_old && new_sz == '0 && live_objs == '0) begin
            batch.push_back(make_rec(ashp_pkg::REC_HEADER, 0, '0, '0, peak_objs,
                                     peak_bytes));
            for (int i = 0; i < NBINS; i++) begin
                if (req_per_bin[i] != '0) begin
                    batch.push_back(make_rec(ashp_pkg::REC_BIN, i, req_per_bin[i],
                                             snap_per_bin[i], '0, '0));
                end
            end
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) pending_records.push_back(batch[i]);
            foreach (req_per_bin[i]) begin
                req_per_bin[i] = '0;
                snap_per_bin[i] = '0;
            end
            peak_objs = '0;
            peak_bytes = '0;
        end
    endtask

    task automatic send_event(input logic had_old, input logic [SIZE_W-1:0] old_sz,
                              input logic [SIZE_W-1:0] new_sz);
        if (gap_pending != 0) begin
            repeat (gap_pending) @(posedge i_clk);
            gap_pending = 0;
        end
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {new_sz, old_sz};
        s_tuser <= had_old;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        tally_event(had_old, old_sz, new_sz);
        items_sent++;
        burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap_pending = $urandom_range(1, 6);
        end
    endtask

    // valid may still be high from an unfinished burst
    task automatic release_input();
        if (burst_left != 0) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_pending = 1;
        end
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        logic [SIZE_W-1:0] v;
        v = SIZE_W'($urandom);
        case ($urandom_range(0, 7))
            0, 1, 2: v = SIZE_W'($urandom_range(1, FINE_LIMIT));
            3:       v = SIZE_W'($urandom_range(FINE_LIMIT + 1, 8192));
            4:       v = SIZE_W'($urandom_range(8193, 24'hFFFFFF));
            5:       v = boundary_sizes[$urandom_range(0, 11)];
            default: if (v == '0) v = 24'd1;
        endcase
        return v;
    endfunction

    // Bring the live object count back to zero so a clean session can dump.
    task automatic settle_live_total();
        while (live_objs != '0) begin
            if ($signed(live_objs) > 0) send_event(1'b1, pick_size(), '0);
            else send_event(1'b0, SIZE_W'($urandom), pick_size());
        end
    endtask

    task automatic alloc_open();
        logic [SIZE_W-1:0] sz;
        sz = pick_size();
        send_event(1'b0, SIZE_W'($urandom), sz);
        open_blocks.push_back(sz);
    endtask

    task automatic free_open(input int idx);
        logic [SIZE_W-1:0] sz;
        sz = open_blocks[idx];
        open_blocks.delete(idx);
        send_event(1'b1, sz, '0);
    endtask

    task automatic test_bin_edges();
        // one allocation on each side of the fine, coarse and catch-all boundaries
        send_event(1'b0, 24'hFFFFFF, 24'd1);
        send_event(1'b0, 24'h000000, 24'd8);
        send_event(1'b0, 24'h5A5A5A, 24'd9);
        send_event(1'b0, 24'hA5A5A5, 24'd256);
        send_event(1'b0, 24'h000000, 24'd257);
        send_event(1'b0, 24'h000000, 24'd512);
        send_event(1'b0, 24'h000000, 24'd513);
        send_event(1'b0, 24'h000000, 24'd8192);
        send_event(1'b0, 24'h000000, 24'd8193);
        send_event(1'b0, 24'h000000, 24'hFFFFFF);
        // free of a zero-size block lands in bin 0
        send_event(1'b1, 24'd0, 24'd0);
        send_event(1'b1, 24'hFFFFFF, 24'hAAAAAA);
        // no old block, no new block: nothing changes
        send_event(1'b0, 24'hFFFFFF, 24'd0);
        send_event(1'b0, 24'd0, 24'd0);
        foreach (boundary_sizes[i]) begin
            if (live_objs != '0) send_event(1'b1, boundary_sizes[i], '0);
        end
        settle_live_total();
    endtask

    task automatic test_overfree();
        // live counts go negative before anything is allocated
        send_event(1'b1, 24'd300, 24'd0);
        send_event(1'b1, 24'd0, 24'd0);
        send_event(1'b0, 24'd7, 24'd40);
        send_event(1'b0, 24'd7, 24'd5000);
        send_event(1'b0, 24'd7, 24'd9000);
        send_event(1'b1, 24'd40, 24'd0);
        settle_live_total();
    endtask

    task automatic test_output_hold();
        settle_live_total();
        hold_asked++;
        repeat (3) begin
            repeat (3) alloc_open();
            while (open_blocks.size() != 0) free_open($urandom_range(0, open_blocks.size() - 1));
        end
    endtask

    task automatic run_session();
        int grow;
        int steps;
        settle_live_total();
        open_blocks.delete();
        grow = $urandom_range(1, 10);
        repeat (grow) alloc_open();
        steps = $urandom_range(0, 8);
        repeat (steps) begin
            case ($urandom_range(0, 2))
                0: alloc_open();
                1: begin
                    int idx;
                    logic [SIZE_W-1:0] nsz;
                    idx = $urandom_range(0, open_blocks.size() - 1);
                    nsz = pick_size();
                    send_event(1'b1, open_blocks[idx], nsz);
                    open_blocks[idx] = nsz;
                end
                default: if (open_blocks.size() > 1)
                    free_open($urandom_range(0, open_blocks.size() - 1));
            endcase
        end
        // now and then a session is abandoned without freeing its blocks
        if ($urandom_range(0, 5) != 0) begin
            while (open_blocks.size() != 0) free_open($urandom_range(0, open_blocks.size() - 1));
        end
        open_blocks.delete();
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 6)) begin
            send_event(1'($urandom_range(0, 1)), SIZE_W'($urandom),
                       ($urandom_range(0, 2) == 0) ? SIZE_W'(0) : pick_size());
        end
    endtask

    task automatic test_random_sessions();
        int start;
        start = items_sent;
        while (items_sent - start < 25) begin
            if ($urandom_range(0, 3) == 0) run_noise();
            else run_session();
        end
        settle_live_total();
    endtask

    task automatic test_peak_epoch();
        // one block grown by resizes: every step is a new byte peak
        int unsigned cur;
        int unsigned nxt;
        settle_live_total();
        cur = 1;
        send_event(1'b0, SIZE_W'($urandom), SIZE_W'(cur));
        repeat (256) begin
            nxt = cur + $urandom_range(1, 60000);
            send_event(1'b1, SIZE_W'(cur), SIZE_W'(nxt));
            cur = nxt;
        end
        send_event(1'b1, SIZE_W'(cur), '0);
    endtask

    task automatic compare_field(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v) begin
            mismatch_count++;
            $display("%0t: %s expected 0x%08h actual 0x%08h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : check_records
        t_dump_rec want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            if (pending_records.size() == 0) begin
                mismatch_count++;
                $display("%0t: record expected none actual kind %0b bin %0d", $time,
                         o_m_axis_tuser, o_m_axis_tdata[5:0]);
            end else begin
                want = pending_records.pop_front();
                compare_field("record_kind", 32'(want.kind), 32'(o_m_axis_tuser));
                compare_field("bin_number", 32'(want.bin), 32'(o_m_axis_tdata[5:0]));
                compare_field("bin_requests", want.reqs, o_m_axis_tdata[37:6]);
                compare_field("bin_live_at_peak", want.at_peak, o_m_axis_tdata[69:38]);
                compare_field("peak_objects", want.pk_objs, o_m_axis_tdata[101:70]);
                compare_field("peak_bytes_out", want.pk_bytes, o_m_axis_tdata[133:102]);
                compare_field("last_of_dump", 32'(want.last), 32'(o_m_axis_tlast));
            end
        end
    end

    // receiver: rotating stall pattern, plus a long hold when a test asks for one
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_served) begin
            m_tready <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_tready <= stall_pattern[pat_pos];
            if (pat_pos == 31) begin
                pat_pos <= 0;
                case ($urandom_range(0, 3))
                    0: stall_pattern <= '1;
                    1: stall_pattern <= $urandom | $urandom;
                    2: stall_pattern <= $urandom;
                    default: stall_pattern <= $urandom & $urandom;
                endcase
            end else begin
                pat_pos <= pat_pos + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (req_per_bin[i]) begin
            req_per_bin[i] = '0;
            live_per_bin[i] = '0;
            snap_per_bin[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_bin_edges();
        test_overfree();
        test_output_hold();
        // live bytes are known and small here, so the epoch test sees a peak every step
        test_peak_epoch();
        test_random_sessions();

        release_input();
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/ashp_pkg.sv
design/ashp_ram.sv
design/alloc_size_histogram_peak.sv
tb/tb_alloc_size_histogram_peak.sv
